@@ sv/fxalu_pkg.sv @@
// Package: shared types, constants and opcodes for the Q24.8 fixed-point ALU.
package fxalu_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int WORD_W         = 32;
   localparam int OP_W           = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_LT      = 4'd5,
      OP_GE      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic signed [WORD_W-1:0] operand_a;
      logic signed [WORD_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_value;
      logic                     compare_true;
      logic                     divide_by_zero;
   } rsp_type;

endpackage

@@ sv/fxalu_cell.sv @@
// One divider cell: one restoring step on the magnitude, plus a carried payload.
module fxalu_cell #(
   parameter int QW = 40,
   parameter int DW = 32,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          vld_in,
   input  logic [QW-1:0] num_in,
   input  logic [DW:0]   rem_in,
   input  logic [DW-1:0] den_in,
   input  logic [PW-1:0] pay_in,
   output logic          vld_out,
   output logic [QW-1:0] num_out,
   output logic [DW:0]   rem_out,
   output logic [DW-1:0] den_out,
   output logic [PW-1:0] pay_out
);

   logic          vld_ff;
   logic [QW-1:0] num_ff;
   logic [DW:0]   rem_ff;
   logic [DW-1:0] den_ff;
   logic [PW-1:0] pay_ff;
   logic [DW+1:0] trial;
   logic [DW:0]   shifted;

   always_comb begin
      shifted = {rem_in[DW-1:0], num_in[QW-1]};
      trial   = {1'b0, shifted} - {2'b00, den_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         den_ff <= den_in;
         pay_ff <= pay_in;
         if (!trial[DW+1]) begin
            rem_ff <= trial[DW:0];
            num_ff <= {num_in[QW-2:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            num_ff <= {num_in[QW-2:0], 1'b0};
         end
      end
   end

   assign vld_out = vld_ff;
   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign pay_out = pay_ff;

endmodule

@@ sv/fixed_point_q24_8_alu.sv @@
// Top level: pipelined Q24.8 fixed-point ALU built on a chain of divider cells.
//
// Usage:
//   req channel: valid/ready, one transfer carries op, operand_a, operand_b.
//   rsp channel: valid/ready, one transfer carries result_value, compare_true,
//   divide_by_zero. One result per request, in request order.
// Pipeline: a request passes one input stage, one cell per quotient bit,
//   a sign-fix stage and the output register on its way to rsp valid.
// Throughput: one transfer per cycle while rsp is not stalled. Every op
//   rides the full cell chain so results leave in order; the quotient bit
//   count sets the depth.
// Stalls: the whole pipe advances together. When rsp is stalled with a
//   result held, the pipe freezes and req_ready drops; req_ready stays high
//   while the output register is empty or being drained.
// Reset: synchronous, clears all valid bits; no result is pending after it.
module fixed_point_q24_8_alu #(
   parameter int FRAC_BITS  = fxalu_pkg::FRAC_BITS_DEF,
   parameter int DATA_WIDTH = fxalu_pkg::DATA_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fxalu_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fxalu_pkg::rsp_type  rsp_data
);

   localparam int DW = DATA_WIDTH;
   localparam int QW = DATA_WIDTH + FRAC_BITS;   // quotient bits
   localparam int PW = DW + 3;                   // result word, cmp, dz, negate
   localparam int WW = fxalu_pkg::WORD_W;

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // input stage: all ops but mul and div resolve here, divide sets up magnitudes
   logic signed [DW-1:0]   a, b;
   logic signed [2*DW-1:0] prod;
   logic [DW-1:0]          res_c;
   logic                   cmp_c, dz_c, neg_c;
   logic [DW-1:0]          mag_a, mag_b;
   logic [QW-1:0]          num_c;

   always_comb begin
      a      = req_data.operand_a[DW-1:0];
      b      = req_data.operand_b[DW-1:0];
      res_c  = '0;
      cmp_c  = 1'b0;
      dz_c   = 1'b0;
      mag_a  = a[DW-1] ? DW'(-a) : DW'(a);
      mag_b  = b[DW-1] ? DW'(-b) : DW'(b);
      neg_c  = a[DW-1] ^ b[DW-1];
      num_c  = {mag_a, {FRAC_BITS{1'b0}}} >> 0;
      unique case (fxalu_pkg::op_type'(req_data.op))
         fxalu_pkg::OP_ADD:     res_c = DW'(a + b);
         fxalu_pkg::OP_SUB:     res_c = DW'(a - b);
         fxalu_pkg::OP_MUL:     res_c = '0;
         fxalu_pkg::OP_DIV:     dz_c  = (b == '0);
         fxalu_pkg::OP_GT:      cmp_c = a > b;
         fxalu_pkg::OP_LT:      cmp_c = a < b;
         fxalu_pkg::OP_GE:      cmp_c = a >= b;
         fxalu_pkg::OP_LE:      cmp_c = a <= b;
         fxalu_pkg::OP_EQ:      cmp_c = a == b;
         fxalu_pkg::OP_NE:      cmp_c = a != b;
         fxalu_pkg::OP_MIN:     res_c = (a < b) ? a : b;
         fxalu_pkg::OP_MAX:     res_c = (a > b) ? a : b;
         fxalu_pkg::OP_INC:     res_c = DW'(a + 1);
         fxalu_pkg::OP_DEC:     res_c = DW'(a - 1);
         fxalu_pkg::OP_TOINT:   res_c = DW'(a >>> FRAC_BITS);
         fxalu_pkg::OP_FROMINT: res_c = DW'(a <<< FRAC_BITS);
         default:               res_c = '0;
      endcase
   end

   // stage 0 register; product is formed after it (a single multiplier)
   logic          s0_vld_ff;
   logic          s0_mul_ff, s0_div_ff;
   logic signed [DW-1:0] s0_a_ff, s0_b_ff;
   logic [DW-1:0] s0_res_ff;
   logic          s0_cmp_ff, s0_dz_ff, s0_neg_ff;
   logic [QW-1:0] s0_num_ff;
   logic [DW-1:0] s0_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
      end
      if (adv) begin
         s0_mul_ff <= req_data.op == fxalu_pkg::OP_MUL;
         s0_div_ff <= (req_data.op == fxalu_pkg::OP_DIV) && (b != '0);
         s0_a_ff   <= a;
         s0_b_ff   <= b;
         s0_res_ff <= res_c;
         s0_cmp_ff <= cmp_c;
         s0_dz_ff  <= dz_c;
         s0_neg_ff <= neg_c;
         s0_num_ff <= num_c;
         s0_den_ff <= (b == '0) ? DW'(1) : mag_b;
      end
   end

   always_comb prod = s0_a_ff * s0_b_ff;

   logic [DW-1:0] s0_word;
   assign s0_word = s0_mul_ff ? DW'(prod >>> FRAC_BITS) : s0_res_ff;

   // cell chain: one quotient bit per cell
   logic          c_vld [QW+1];
   logic [QW-1:0] c_num [QW+1];
   logic [DW:0]   c_rem [QW+1];
   logic [DW-1:0] c_den [QW+1];
   logic [PW-1:0] c_pay [QW+1];

   assign c_vld[0] = s0_vld_ff;
   assign c_num[0] = s0_num_ff;
   assign c_rem[0] = '0;
   assign c_den[0] = s0_den_ff;
   assign c_pay[0] = {s0_word, s0_cmp_ff, s0_dz_ff, s0_div_ff & s0_neg_ff};

   // divide tag travels beside the chain, one bit per cell
   logic [QW-1:0] div_tag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         div_tag_ff <= {div_tag_ff[QW-2:0], s0_div_ff};
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_cell
      fxalu_cell #(.QW(QW), .DW(DW), .PW(PW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .vld_in  (c_vld[i]),
         .num_in  (c_num[i]),
         .rem_in  (c_rem[i]),
         .den_in  (c_den[i]),
         .pay_in  (c_pay[i]),
         .vld_out (c_vld[i+1]),
         .num_out (c_num[i+1]),
         .rem_out (c_rem[i+1]),
         .den_out (c_den[i+1]),
         .pay_out (c_pay[i+1])
      );
   end

   // sign-fix stage, then output register
   logic          sf_vld_ff;
   logic [DW-1:0] sf_word_ff;
   logic          sf_cmp_ff, sf_dz_ff;
   logic [QW-1:0] q;
   logic [DW-1:0] qword;
   logic [PW-1:0] last;

   assign q     = c_num[QW];
   assign last  = c_pay[QW];
   assign qword = last[0] ? DW'(-q) : DW'(q);

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_vld_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         sf_vld_ff <= c_vld[QW];
         rsp_valid <= sf_vld_ff;
      end
      if (adv) begin
         sf_word_ff <= div_tag_ff[QW-1] ? qword : last[PW-1:3];
         sf_cmp_ff  <= last[2];
         sf_dz_ff   <= last[1];
         rsp_data.result_value   <= WW'(signed'(sf_word_ff));
         rsp_data.compare_true   <= sf_cmp_ff;
         rsp_data.divide_by_zero <= sf_dz_ff;
      end
   end

endmodule

@@ sv/fxalu_checker.sv @@
// Checker: port-level properties of the fixed-point ALU, bound to the top level.
module fxalu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input fxalu_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while output stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req blocked with empty output");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         !rsp_data.compare_true && rsp_data.result_value == '0)
      else $error("divide by zero result malformed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind fixed_point_q24_8_alu fxalu_checker u_fxalu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/fxalu_checker.sv @@
// Checker: watches both channels of the Q24.8 ALU, predicts each result and compares.
`timescale 1ns / 100ps
module fxalu_scoreboard (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  fxalu_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  fxalu_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 rsp_seen
);

   fxalu_pkg::rsp_type alu_results_due[$];

   function automatic fxalu_pkg::rsp_type alu_predict(fxalu_pkg::req_type r);
      fxalu_pkg::rsp_type o;
      logic signed [63:0] a, b, w;
      a = 64'(r.operand_a);
      b = 64'(r.operand_b);
      o = '0;
      w = 0;
      case (fxalu_pkg::op_type'(r.op))
         fxalu_pkg::OP_ADD:     w = a + b;
         fxalu_pkg::OP_SUB:     w = a - b;
         fxalu_pkg::OP_MUL:     w = (a * b) >>> 8;
         fxalu_pkg::OP_DIV: begin
            if (b == 0) o.divide_by_zero = 1'b1;
            else w = (a <<< 8) / b;
         end
         fxalu_pkg::OP_GT:      o.compare_true = a > b;
         fxalu_pkg::OP_LT:      o.compare_true = a < b;
         fxalu_pkg::OP_GE:      o.compare_true = a >= b;
         fxalu_pkg::OP_LE:      o.compare_true = a <= b;
         fxalu_pkg::OP_EQ:      o.compare_true = a == b;
         fxalu_pkg::OP_NE:      o.compare_true = a != b;
         fxalu_pkg::OP_MIN:     w = (a < b) ? a : b;
         fxalu_pkg::OP_MAX:     w = (a > b) ? a : b;
         fxalu_pkg::OP_INC:     w = a + 1;
         fxalu_pkg::OP_DEC:     w = a - 1;
         fxalu_pkg::OP_TOINT:   w = a >>> 8;
         default:               w = a <<< 8;
      endcase
      o.result_value = w[31:0];
      return o;
   endfunction

   always @(posedge clock) begin
      fxalu_pkg::rsp_type exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         alu_results_due.delete();
         fail_count <= 0;
         rsp_seen   <= 0;
      end else begin
         if (req_valid && req_ready) alu_results_due.push_back(alu_predict(req_data));
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (alu_results_due.size() == 0) begin
               $error("result with nothing outstanding: %h", rsp_data);
               errs++;
            end else begin
               exp_r = alu_results_due.pop_front();
               if (exp_r.result_value !== rsp_data.result_value) begin
                  $error("result_value expected %h actual %h",
                         exp_r.result_value, rsp_data.result_value);
                  errs++;
               end
               if (exp_r.compare_true !== rsp_data.compare_true) begin
                  $error("compare_true expected %b actual %b",
                         exp_r.compare_true, rsp_data.compare_true);
                  errs++;
               end
               if (exp_r.divide_by_zero !== rsp_data.divide_by_zero) begin
                  $error("divide_by_zero expected %b actual %b",
                         exp_r.divide_by_zero, rsp_data.divide_by_zero);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= alu_results_due.size();
   end
endmodule

@@ tb/sv/tb_fixed_point_q24_8_alu.sv @@
// Testbench top: stimulus, flow control and verdict for the Q24.8 fixed-point ALU.
`timescale 1ns / 100ps
module tb_fixed_point_q24_8_alu;

   localparam int LATENCY     = 43;     // pipeline depth of the ALU at default sizes
   localparam int N_RANDOM    = 1880;
   localparam int HOLD_CYCLES = 200;    // long receiver hold-off
   localparam int STALL_LIMIT = 2000;   // cycles with no transfer at all

   logic    clock, reset;
   logic    req_valid, req_ready, rsp_valid, rsp_ready;
   fxalu_pkg::req_type req_data;
   fxalu_pkg::rsp_type rsp_data;
   int      fail_count, pending_count, rsp_seen;
   int      req_sent;
   bit      quiet_phase;    // last part of run: no idling on either side
   bit      hold_off_req;   // asks the receiver for one long hold-off
   bit      hold_off_done;
   int      idle_cycles;

   fixed_point_q24_8_alu dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   fxalu_scoreboard u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .fail_count, .pending_count, .rsp_seen
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: random back-pressure bursts, plus one long hold-off on request.
   initial begin
      int n;
      rsp_ready     = 1'b0;
      hold_off_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog: ends the run if the channels go quiet for too long.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // One transfer: payload set on the falling edge, held until accepted.
   // Valid stays high afterwards; the caller drops it before any gap.
   task automatic send_op(fxalu_pkg::op_type op, logic [31:0] a, logic [31:0] b);
      req_data  <= '{op: op, operand_a: a, operand_b: b};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 3) - 1;              // -1, 0, 1, 2
         3: return 32'($signed($urandom_range(0, 4095)) - 2048);
         4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] edge_vals [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                     32'h1, 32'hFFFF_FFFF, 32'h0000_0100};
      logic [31:0] a, b;
      fxalu_pkg::op_type op;
      int          timer;
      int          gap;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      req_sent     = 0;
      quiet_phase  = 1'b0;
      hold_off_req = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed: each opcode on extreme operands, then divide by zero, min/max
      // ties, the most negative divided by minus one, a multiply and conversions.
      for (int k = 0; k < 16; k++)
         send_op(fxalu_pkg::op_type'(k), edge_vals[k % 6], edge_vals[(k + 2) % 6]);
      send_op(fxalu_pkg::OP_DIV, 32'h0000_1234, 32'h0);
      send_op(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
      send_op(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_op(fxalu_pkg::OP_MIN, 32'hFFFF_FF80, 32'hFFFF_FF80);
      send_op(fxalu_pkg::OP_MAX, 32'h0000_0500, 32'h0000_0500);
      send_op(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send_op(fxalu_pkg::OP_TOINT, 32'hFFFF_FFFF, 32'h0);
      send_op(fxalu_pkg::OP_FROMINT, 32'h00FF_FFFF, 32'h0);
      req_valid <= 1'b0;

      // Sender pause until everything outstanding has drained.
      while (pending_count != 0) @(negedge clock);

      // Random items; the receiver holds off once, early, to fill the pipe.
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 100) hold_off_req = 1'b1;
         if (i == N_RANDOM - 300) quiet_phase = 1'b1;
         op = fxalu_pkg::op_type'($urandom_range(0, 15));
         a  = rand_operand();
         // equal operands often, to reach compare and min/max ties
         b  = ($urandom_range(0, 5) == 0) ? a : rand_operand();
         if (op == fxalu_pkg::OP_DIV && $urandom_range(0, 9) == 0) b = 32'h0;
         send_op(op, a, b);
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      timer = 0;
      while (pending_count != 0 && timer < 20000) begin
         @(negedge clock);
         timer++;
      end
      repeat (LATENCY + 10) @(negedge clock);

      $display("covered %0d requests, %0d results: all 16 opcodes, operand extremes,",
               req_sent, rsp_seen);
      $display("divide by zero, ties, random back-pressure and a full-pipe stall");
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ sim.f @@
sv/fxalu_pkg.sv
sv/fxalu_cell.sv
sv/fixed_point_q24_8_alu.sv
sv/fxalu_checker.sv
tb/sv/fxalu_checker.sv
tb/sv/tb_fixed_point_q24_8_alu.sv
